[design/rtbe_pkg.sv]
// Shared types, codes and constants for the RLE texture block expander.
`default_nettype none

package rtbe_pkg;

    localparam int ADDR_BITS  = 24;
    localparam int COUNT_BITS = 14;
    localparam int PADDR_BITS = 3;

    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [1:0]            code_t;

    // Commands
    localparam code_t CMD_START = 2'd0;
    localparam code_t CMD_RUN   = 2'd1;
    localparam code_t CMD_NEXT  = 2'd2;
    localparam code_t CMD_END   = 2'd3;

    // Run operations
    localparam code_t OP_CONST   = 2'd0;
    localparam code_t OP_FOUR    = 2'd1;
    localparam code_t OP_MIXED   = 2'd2;
    localparam code_t OP_UNKNOWN = 2'd3;

    // Block kinds
    localparam code_t KIND_WHITE  = 2'd0;
    localparam code_t KIND_BLACK  = 2'd1;
    localparam code_t KIND_FOUR   = 2'd2;
    localparam code_t KIND_OPAQUE = 2'd3;

    // Status codes
    localparam code_t ST_OK          = 2'd0;
    localparam code_t ST_UNKNOWN_OP  = 2'd1;
    localparam code_t ST_OUT_OF_SYNC = 2'd2;
    localparam code_t ST_NO_RUN      = 2'd3;

    // Register indexes
    localparam logic REG_RLES_MODE = 1'b0;

    // Pointer advances
    localparam addr_t ADV_ALPHA_END   = addr_t'(2);
    localparam addr_t ADV_ALPHA_INDEX = addr_t'(6);
    localparam addr_t ADV_COLOR       = addr_t'(4);
    localparam addr_t ADV_EXTRA       = addr_t'(16);

    typedef struct packed {
        addr_t  alpha_end_ptr;
        addr_t  alpha_index_ptr;
        addr_t  color_end_ptr;
        addr_t  color_index_ptr;
        addr_t  extra_ptr;
        code_t  run_operation;
        count_t run_remaining;
    } state_t;

    typedef struct packed {
        logic  block_valid;
        code_t block_kind;
        addr_t alpha_end_addr;
        addr_t alpha_index_addr;
        addr_t color_end_addr;
        addr_t color_index_addr;
        logic  run_done;
        code_t status;
    } result_t;

endpackage

`default_nettype wire

[design/rtbe_step.sv]
// Next-state and result logic for one command word.
`default_nettype none

module rtbe_step (
    input  wire rtbe_pkg::state_t  state,
    input  wire                    rles_mode,
    input  wire rtbe_pkg::code_t   command,
    input  wire [15:0]             run_word,
    input  wire rtbe_pkg::addr_t   alpha_end_offset,
    input  wire rtbe_pkg::addr_t   alpha_index_offset,
    input  wire rtbe_pkg::addr_t   color_end_offset,
    input  wire rtbe_pkg::addr_t   color_index_offset,
    input  wire rtbe_pkg::addr_t   extra_offset,
    output rtbe_pkg::state_t       state_next,
    output rtbe_pkg::result_t      result
);
    import rtbe_pkg::*;

    logic four;
    logic bad;

    always_comb
    begin
        state_next = state;
        result     = '0;
        four       = (state.run_operation == OP_FOUR) ||
                     (rles_mode && state.run_operation == OP_MIXED);
        bad        = (state.alpha_end_ptr != alpha_end_offset) ||
                     (state.alpha_index_ptr != alpha_index_offset) ||
                     (state.color_end_ptr != color_end_offset) ||
                     (state.color_index_ptr != color_index_offset) ||
                     (rles_mode && state.extra_ptr != extra_offset);
        case (command)
            CMD_START:
            begin
                state_next.alpha_end_ptr   = alpha_end_offset;
                state_next.alpha_index_ptr = alpha_index_offset;
                state_next.color_end_ptr   = color_end_offset;
                state_next.color_index_ptr = color_index_offset;
                state_next.extra_ptr       = extra_offset;
                state_next.run_operation   = OP_CONST;
                state_next.run_remaining   = '0;
            end
            CMD_RUN:
            begin
                state_next.run_operation = run_word[1:0];
                if (run_word[1:0] == OP_UNKNOWN)
                begin
                    state_next.run_remaining = '0;
                    result.status            = ST_UNKNOWN_OP;
                end
                else
                begin
                    state_next.run_remaining = run_word[15:2];
                end
            end
            CMD_NEXT:
            begin
                if (state.run_remaining == '0)
                begin
                    result.status = ST_NO_RUN;
                end
                else
                begin
                    result.block_valid = 1'b1;
                    if (state.run_operation == OP_CONST)
                    begin
                        result.block_kind = rles_mode ? KIND_BLACK : KIND_WHITE;
                    end
                    else if (four)
                    begin
                        result.block_kind          = KIND_FOUR;
                        result.alpha_end_addr      = state.alpha_end_ptr;
                        result.alpha_index_addr    = state.alpha_index_ptr;
                        result.color_end_addr      = state.color_end_ptr;
                        result.color_index_addr    = state.color_index_ptr;
                        state_next.alpha_end_ptr   = state.alpha_end_ptr + ADV_ALPHA_END;
                        state_next.alpha_index_ptr = state.alpha_index_ptr + ADV_ALPHA_INDEX;
                        state_next.color_end_ptr   = state.color_end_ptr + ADV_COLOR;
                        state_next.color_index_ptr = state.color_index_ptr + ADV_COLOR;
                        if (rles_mode && state.run_operation == OP_FOUR)
                        begin
                            state_next.extra_ptr = state.extra_ptr + ADV_EXTRA;
                        end
                    end
                    else
                    begin
                        result.block_kind          = KIND_OPAQUE;
                        result.color_end_addr      = state.color_end_ptr;
                        result.color_index_addr    = state.color_index_ptr;
                        state_next.color_end_ptr   = state.color_end_ptr + ADV_COLOR;
                        state_next.color_index_ptr = state.color_index_ptr + ADV_COLOR;
                    end
                    state_next.run_remaining = state.run_remaining - count_t'(1);
                    result.run_done          = (state.run_remaining == count_t'(1));
                end
            end
            CMD_END:
            begin
                if (bad)
                begin
                    result.status = ST_OUT_OF_SYNC;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/rle_texture_block_expander.sv]
// Top level of the RLE texture block expander: handshake, state, result register, APB.
// The result word of an accepted command word is registered; it is valid from the cycle after the word is accepted.
// Throughput: one word per cycle while out_ready is high; the result register is refilled in the cycle it drains.
// Each command word gives exactly one result word.
// Reset: rst_n clears the plane pointers, the pending run, rles_mode and the result valid.
`default_nettype none

module rle_texture_block_expander (
    input  wire                              clk,
    input  wire                              rst_n,
    // APB configuration
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [rtbe_pkg::PADDR_BITS-1:0]   paddr,
    input  wire [31:0]                       pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // Command channel
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire rtbe_pkg::code_t             command,
    input  wire [15:0]                       run_word,
    input  wire rtbe_pkg::addr_t             alpha_end_offset,
    input  wire rtbe_pkg::addr_t             alpha_index_offset,
    input  wire rtbe_pkg::addr_t             color_end_offset,
    input  wire rtbe_pkg::addr_t             color_index_offset,
    input  wire rtbe_pkg::addr_t             extra_offset,
    // Result channel
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic                             block_valid,
    output rtbe_pkg::code_t                  block_kind,
    output rtbe_pkg::addr_t                  alpha_end_addr,
    output rtbe_pkg::addr_t                  alpha_index_addr,
    output rtbe_pkg::addr_t                  color_end_addr,
    output rtbe_pkg::addr_t                  color_index_addr,
    output logic                             run_done,
    output rtbe_pkg::code_t                  status
);
    import rtbe_pkg::*;

    logic    rles_mode_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg;
    logic    in_fire;
    logic    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[PADDR_BITS-1] == REG_RLES_MODE) ? {31'b0, rles_mode_reg} : 32'b0;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    rtbe_step u_step (
        .state              (state_reg),
        .rles_mode          (rles_mode_reg),
        .command            (command),
        .run_word           (run_word),
        .alpha_end_offset   (alpha_end_offset),
        .alpha_index_offset (alpha_index_offset),
        .color_end_offset   (color_end_offset),
        .color_index_offset (color_index_offset),
        .extra_offset       (extra_offset),
        .state_next         (state_next),
        .result             (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rles_mode_reg <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && paddr[PADDR_BITS-1] == REG_RLES_MODE)
            begin
                rles_mode_reg <= pwdata[0];
            end
            if (in_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign block_valid      = result_reg.block_valid;
    assign block_kind       = result_reg.block_kind;
    assign alpha_end_addr   = result_reg.alpha_end_addr;
    assign alpha_index_addr = result_reg.alpha_index_addr;
    assign color_end_addr   = result_reg.color_end_addr;
    assign color_index_addr = result_reg.color_index_addr;
    assign run_done         = result_reg.run_done;
    assign status           = result_reg.status;

    a_block_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.block_valid) |-> (result_reg.status == ST_OK))
        else $error("emitted block carries an error status");

    a_done_block: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.run_done) |-> result_reg.block_valid)
        else $error("run_done without a block");

    a_no_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && command == CMD_NEXT && state_reg.run_remaining == '0)
        |=> (out_valid_reg && result_reg.status == ST_NO_RUN && !result_reg.block_valid))
        else $error("next block without pending run not refused");

    a_const_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.block_kind == KIND_WHITE ||
                           result_reg.block_kind == KIND_BLACK))
        |-> (result_reg.alpha_end_addr == '0 && result_reg.alpha_index_addr == '0 &&
             result_reg.color_end_addr == '0 && result_reg.color_index_addr == '0))
        else $error("constant block carries an address");

endmodule

`default_nettype wire

[sim/expander_check_pkg.sv]
// Scoreboard that predicts and checks the block descriptors of the RLE texture block expander.
`timescale 1ns / 100ps

package expander_check_pkg;

    import rtbe_pkg::*;

    class block_expander_scoreboard;

        logic    rles;
        addr_t   ae_ptr;
        addr_t   ai_ptr;
        addr_t   ce_ptr;
        addr_t   ci_ptr;
        addr_t   ex_ptr;
        code_t   run_op;
        count_t  blocks_left;
        result_t descriptor_q[$];
        int      errors;
        int      words_checked;
        int      kind_count[4];
        int      status_count[4];

        function new();
            rles          = 1'b0;
            ae_ptr        = '0;
            ai_ptr        = '0;
            ce_ptr        = '0;
            ci_ptr        = '0;
            ex_ptr        = '0;
            run_op        = OP_CONST;
            blocks_left   = '0;
            errors        = 0;
            words_checked = 0;
            foreach (kind_count[k])
            begin
                kind_count[k]   = 0;
                status_count[k] = 0;
            end
        endfunction

        function int outstanding();
            return descriptor_q.size();
        endfunction

        function void note_command(code_t cmd, logic [15:0] word, addr_t ae_in, addr_t ai_in,
                                   addr_t ce_in, addr_t ci_in, addr_t ex_in);
            result_t want;
            logic    four;
            want        = '0;
            want.status = ST_OK;
            case (cmd)
                CMD_START:
                begin
                    ae_ptr      = ae_in;
                    ai_ptr      = ai_in;
                    ce_ptr      = ce_in;
                    ci_ptr      = ci_in;
                    ex_ptr      = ex_in;
                    run_op      = OP_CONST;
                    blocks_left = '0;
                end
                CMD_RUN:
                begin
                    run_op = word[1:0];
                    if (run_op == OP_UNKNOWN)
                    begin
                        blocks_left = '0;
                        want.status = ST_UNKNOWN_OP;
                    end
                    else
                    begin
                        blocks_left = word[15:2];
                    end
                end
                CMD_NEXT:
                begin
                    if (blocks_left == '0)
                    begin
                        want.status = ST_NO_RUN;
                    end
                    else
                    begin
                        four = (run_op == OP_FOUR) || (rles && run_op == OP_MIXED);
                        want.block_valid = 1'b1;
                        if (run_op == OP_CONST)
                        begin
                            want.block_kind = rles ? KIND_BLACK : KIND_WHITE;
                        end
                        else if (four)
                        begin
                            want.block_kind       = KIND_FOUR;
                            want.alpha_end_addr   = ae_ptr;
                            want.alpha_index_addr = ai_ptr;
                            want.color_end_addr   = ce_ptr;
                            want.color_index_addr = ci_ptr;
                            ae_ptr = ae_ptr + ADV_ALPHA_END;
                            ai_ptr = ai_ptr + ADV_ALPHA_INDEX;
                            ce_ptr = ce_ptr + ADV_COLOR;
                            ci_ptr = ci_ptr + ADV_COLOR;
                            if (rles && run_op == OP_FOUR)
                                ex_ptr = ex_ptr + ADV_EXTRA;
                        end
                        else
                        begin
                            want.block_kind       = KIND_OPAQUE;
                            want.color_end_addr   = ce_ptr;
                            want.color_index_addr = ci_ptr;
                            ce_ptr = ce_ptr + ADV_COLOR;
                            ci_ptr = ci_ptr + ADV_COLOR;
                        end
                        blocks_left   = blocks_left - count_t'(1);
                        want.run_done = (blocks_left == '0);
                    end
                end
                default:
                begin
                    if (ae_ptr != ae_in || ai_ptr != ai_in || ce_ptr != ce_in ||
                        ci_ptr != ci_in || (rles && ex_ptr != ex_in))
                        want.status = ST_OUT_OF_SYNC;
                end
            endcase
            descriptor_q.push_back(want);
        endfunction

        function void field_diff(string name, logic [23:0] want_v, logic [23:0] got_v);
            if (got_v !== want_v)
            begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_block(result_t got);
            result_t want;
            if (descriptor_q.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = descriptor_q.pop_front();
            words_checked++;
            status_count[want.status]++;
            if (want.block_valid)
                kind_count[want.block_kind]++;
            field_diff("block_valid", 24'(want.block_valid), 24'(got.block_valid));
            field_diff("block_kind", 24'(want.block_kind), 24'(got.block_kind));
            field_diff("alpha_end_addr", want.alpha_end_addr, got.alpha_end_addr);
            field_diff("alpha_index_addr", want.alpha_index_addr, got.alpha_index_addr);
            field_diff("color_end_addr", want.color_end_addr, got.color_end_addr);
            field_diff("color_index_addr", want.color_index_addr, got.color_index_addr);
            field_diff("run_done", 24'(want.run_done), 24'(got.run_done));
            field_diff("status", 24'(want.status), 24'(got.status));
        endfunction

        function int close_out();
            while (descriptor_q.size() != 0)
            begin
                $display("%0t: missing word: expected %h, actual none", $time,
                         descriptor_q.pop_front());
                errors++;
            end
            return errors;
        endfunction

    endclass

endpackage

[sim/tb.sv]
// Testbench top for the RLE texture block expander: stimulus, handshakes and final verdict.
`timescale 1ns / 100ps

module tb;

    import rtbe_pkg::*;
    import expander_check_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    code_t                 command;
    logic [15:0]           run_word;
    addr_t                 alpha_end_offset;
    addr_t                 alpha_index_offset;
    addr_t                 color_end_offset;
    addr_t                 color_index_offset;
    addr_t                 extra_offset;
    logic                  out_valid;
    logic                  out_ready;
    logic                  block_valid;
    code_t                 block_kind;
    addr_t                 alpha_end_addr;
    addr_t                 alpha_index_addr;
    addr_t                 color_end_addr;
    addr_t                 color_index_addr;
    logic                  run_done;
    code_t                 status;
    result_t               observed;

    block_expander_scoreboard sb;
    bit                       quiet;
    int                       stall_hold;
    int                       words_sent;

    rle_texture_block_expander u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .command            (command),
        .run_word           (run_word),
        .alpha_end_offset   (alpha_end_offset),
        .alpha_index_offset (alpha_index_offset),
        .color_end_offset   (color_end_offset),
        .color_index_offset (color_index_offset),
        .extra_offset       (extra_offset),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .block_valid        (block_valid),
        .block_kind         (block_kind),
        .alpha_end_addr     (alpha_end_addr),
        .alpha_index_addr   (alpha_index_addr),
        .color_end_addr     (color_end_addr),
        .color_index_addr   (color_index_addr),
        .run_done           (run_done),
        .status             (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    assign observed = {block_valid, block_kind, alpha_end_addr, alpha_index_addr,
                       color_end_addr, color_index_addr, run_done, status};

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_block(observed);
    end

    initial
    begin
        #2_000_000;
        $display("FAIL rle_texture_block_expander");
        $finish;
    end

    initial
    begin
        int w;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (stall_hold > 0)
            begin
                w          = stall_hold;
                stall_hold = 0;
            end
            else
            begin
                w = quiet ? 0 : $urandom_range(0, 4);
            end
            if (w > 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    function automatic addr_t any_ptr();
        return addr_t'($urandom);
    endfunction

    function automatic addr_t start_ptr(bit near_wrap);
        return near_wrap ? {16'hFFFF, 8'($urandom)} : any_ptr();
    endfunction

    task automatic send_word(input code_t cmd, input logic [15:0] word, input addr_t ae,
                             input addr_t ai, input addr_t ce, input addr_t ci,
                             input addr_t ex);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid           <= 1'b1;
        command            <= cmd;
        run_word           <= word;
        alpha_end_offset   <= ae;
        alpha_index_offset <= ai;
        color_end_offset   <= ce;
        color_index_offset <= ci;
        extra_offset       <= ex;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sb.note_command(cmd, word, ae, ai, ce, ci, ex);
        words_sent++;
    endtask

    task automatic send_filler(input code_t cmd, input logic [15:0] word);
        send_word(cmd, word, any_ptr(), any_ptr(), any_ptr(), any_ptr(), any_ptr());
    endtask

    task automatic end_check(input bit corrupt);
        addr_t ptrs[5];
        int    f;
        ptrs[0] = sb.ae_ptr;
        ptrs[1] = sb.ai_ptr;
        ptrs[2] = sb.ce_ptr;
        ptrs[3] = sb.ci_ptr;
        ptrs[4] = sb.rles ? sb.ex_ptr : any_ptr();
        if (corrupt)
        begin
            f = $urandom_range(0, 4);
            ptrs[f][$urandom_range(0, ADDR_BITS - 1)] ^= 1'b1;
        end
        send_word(CMD_END, 16'($urandom), ptrs[0], ptrs[1], ptrs[2], ptrs[3], ptrs[4]);
    endtask

    task automatic start_level();
        bit nw;
        nw = ($urandom_range(0, 3) == 0);
        send_word(CMD_START, 16'($urandom), start_ptr(nw), start_ptr(nw), start_ptr(nw),
                  start_ptr(nw), start_ptr(nw));
    endtask

    task automatic drain(input int settle);
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (sb.outstanding() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_mode(input logic mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_BITS'(REG_RLES_MODE) << 2;
        pwdata  <= {31'($urandom), mode};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.rles = mode;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_phase(input int n_words);
        int    stop_at;
        int    nruns;
        int    nnext;
        int    count;
        int    pick;
        code_t op;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_filler(code_t'($urandom_range(0, 3)), 16'($urandom));
            end
            else
            begin
                start_level();
                nruns = $urandom_range(1, 4);
                repeat (nruns)
                begin
                    pick = $urandom_range(0, 19);
                    op   = (pick == 0) ? OP_UNKNOWN : code_t'($urandom_range(0, 2));
                    if (pick == 1)
                        count = 0;
                    else if (pick == 2)
                        count = $urandom_range(7, 40);
                    else
                        count = $urandom_range(1, 6);
                    send_filler(CMD_RUN, {14'(count), op});
                    nnext = (op == OP_UNKNOWN || count == 0) ? 1 : count;
                    pick  = $urandom_range(0, 9);
                    if (pick == 0 && nnext > 1)
                        nnext = $urandom_range(1, nnext - 1);
                    else if (pick == 1)
                        nnext++;
                    repeat (nnext) send_filler(CMD_NEXT, 16'($urandom));
                end
                end_check($urandom_range(0, 6) == 0);
            end
        end
    endtask

    initial
    begin
        sb                 = new();
        quiet              = 1'b0;
        stall_hold         = 0;
        words_sent         = 0;
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_valid           <= 1'b0;
        command            <= CMD_START;
        run_word           <= '0;
        alpha_end_offset   <= '0;
        alpha_index_offset <= '0;
        color_end_offset   <= '0;
        color_index_offset <= '0;
        extra_offset       <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_mode(1'b0);
        send_word(CMD_NEXT, 16'hFFFF, '1, '1, '1, '1, '1);
        send_word(CMD_END, 16'h0000, '0, '0, '0, '0, '0);
        send_word(CMD_START, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFC, 24'hFFFFFE, 24'h000000,
                  24'hFFFFF8);
        send_filler(CMD_RUN, {14'd2, OP_FOUR});
        send_filler(CMD_NEXT, 16'h0000);
        send_filler(CMD_NEXT, 16'hFFFF);
        send_filler(CMD_RUN, {14'd1, OP_MIXED});
        send_filler(CMD_NEXT, 16'h0000);
        send_filler(CMD_RUN, {14'd1, OP_CONST});
        send_filler(CMD_NEXT, 16'h0000);
        send_filler(CMD_RUN, 16'hFFFF);
        send_filler(CMD_NEXT, 16'h0000);
        send_filler(CMD_RUN, {14'd0, OP_FOUR});
        send_filler(CMD_NEXT, 16'h0000);
        send_filler(CMD_RUN, {14'h3FFF, OP_FOUR});
        send_filler(CMD_NEXT, 16'h0000);
        send_filler(CMD_RUN, {14'd2, OP_MIXED});
        send_filler(CMD_NEXT, 16'h0000);
        end_check(1'b0);
        end_check(1'b1);
        send_word(CMD_START, 16'h0000, '0, '0, '0, '0, '0);
        send_filler(CMD_NEXT, 16'h0000);
        drain(3);

        set_mode(1'b1);
        send_word(CMD_START, 16'h0000, 24'hFFFFFE, 24'hFFFFFA, 24'hFFFFFC, 24'hFFFFFC,
                  24'hFFFFF0);
        send_filler(CMD_RUN, {14'd1, OP_FOUR});
        send_filler(CMD_NEXT, 16'h0000);
        send_filler(CMD_RUN, {14'd1, OP_MIXED});
        send_filler(CMD_NEXT, 16'h0000);
        send_filler(CMD_RUN, {14'd1, OP_CONST});
        send_filler(CMD_NEXT, 16'h0000);
        end_check(1'b0);
        send_word(CMD_END, 16'h0000, sb.ae_ptr, sb.ai_ptr, sb.ce_ptr, sb.ci_ptr,
                  sb.ex_ptr ^ 24'h000001);
        drain(3);

        for (int phase = 0; phase < 6; phase++)
        begin
            set_mode(phase[0]);
            quiet = (phase == 3);
            if (phase == 2)
                stall_hold = 150;
            random_phase(145);
            drain(3);
        end
        quiet = 1'b0;

        drain(5);
        $display("Run covered %0d command words in both modes: %0d checked, blocks white %0d,",
                 words_sent, sb.words_checked, sb.kind_count[KIND_WHITE]);
        $display("  black %0d, four %0d, opaque %0d; ok %0d, bad op %0d, sync %0d, idle %0d.",
                 sb.kind_count[KIND_BLACK], sb.kind_count[KIND_FOUR],
                 sb.kind_count[KIND_OPAQUE], sb.status_count[ST_OK],
                 sb.status_count[ST_UNKNOWN_OP], sb.status_count[ST_OUT_OF_SYNC],
                 sb.status_count[ST_NO_RUN]);
        if (sb.close_out() == 0)
            $display("PASS rle_texture_block_expander");
        else
            $display("FAIL rle_texture_block_expander");
        $finish;
    end

endmodule

[rle_texture_block_expander.f]
design/rtbe_pkg.sv
design/rtbe_step.sv
design/rle_texture_block_expander.sv
sim/expander_check_pkg.sv
sim/tb.sv
